FILE: rtl/dltq_pkg.sv
// Shared types, codes and sizes of the delta list timeout queue.
`default_nettype none

package dltq_pkg;

   // Queue size and the width of the entry counter
   localparam int QUEUE_DEPTH = 16;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int DELAY_W   = 32;
   localparam int HANDLER_W = 8;
   localparam int ARG_W     = 16;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 5;

   // Request kinds on req_tuser
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

   // Operation carried by the wave
   localparam logic [1:0] OP_NOP = 2'd0;
   localparam logic [1:0] OP_INS = 2'd1;
   localparam logic [1:0] OP_REM = 2'd2;

   // Wave modes as it moves down the chain
   localparam logic [1:0] MODE_SEARCH = 2'd0;
   localparam logic [1:0] MODE_SHIFT  = 2'd1;
   localparam logic [1:0] MODE_PULL   = 2'd2;
   localparam logic [1:0] MODE_IDLE   = 2'd3;

   // One queue entry
   typedef struct packed {
      logic [DELAY_W-1:0]   delta;
      logic [HANDLER_W-1:0] handler;
      logic [ARG_W-1:0]     arg;
   } entry_type;

   // Token handed from cell to cell, one per request
   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [1:0]         mode;
      logic [DELAY_W-1:0] rest;
      entry_type          ent;
      logic               hit;
   } wave_type;

endpackage

`default_nettype wire

FILE: rtl/dltq_cell.sv
// One cell of the queue chain: holds one entry and processes the passing wave.
`default_nettype none

module dltq_cell
   import dltq_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire wave_type  up_wave,
   input  wire logic      occupied,
   input  wire logic      hold,
   input  wire entry_type next_ent,
   output wire wave_type  down_wave,
   output wire entry_type ent_out
);

   wave_type  wave_ff;
   wave_type  wave_in;
   entry_type ent_ff;
   entry_type ent_in;

   logic              match;
   logic [DELAY_W-1:0] pull_add;

   assign match = (ent_ff.handler == up_wave.ent.handler) && (ent_ff.arg == up_wave.ent.arg);

   // Delta added to the entry pulled in from the right
   assign pull_add = (up_wave.mode == MODE_PULL) ? up_wave.rest : ent_ff.delta;

   // Act on the wave and hand it on
   always_comb begin
      wave_in = up_wave;
      ent_in  = ent_ff;
      if (up_wave.valid) begin
         case (up_wave.mode)
            MODE_SEARCH: begin
               if (up_wave.op == OP_INS) begin
                  if (!occupied || (ent_ff.delta > up_wave.rest)) begin
                     // place the new entry here, push the old one right
                     ent_in.delta   = up_wave.rest;
                     ent_in.handler = up_wave.ent.handler;
                     ent_in.arg     = up_wave.ent.arg;
                     wave_in.hit    = 1'b1;
                     wave_in.ent    = ent_ff;
                     if (occupied) begin
                        wave_in.ent.delta = ent_ff.delta - up_wave.rest;
                        wave_in.mode      = MODE_SHIFT;
                     end else begin
                        wave_in.mode = MODE_IDLE;
                     end
                  end else begin
                     wave_in.rest = up_wave.rest - ent_ff.delta;
                  end
               end else if ((up_wave.op == OP_REM) && occupied && match) begin
                  // drop this entry, pull the successor in with the added delta
                  ent_in       = next_ent;
                  ent_in.delta = next_ent.delta + pull_add;
                  wave_in.hit  = 1'b1;
                  wave_in.mode = MODE_PULL;
                  wave_in.rest = '0;
               end
            end
            MODE_SHIFT: begin
               ent_in      = up_wave.ent;
               wave_in.ent = ent_ff;
               if (!occupied) begin
                  wave_in.mode = MODE_IDLE;
               end
            end
            MODE_PULL: begin
               ent_in       = next_ent;
               ent_in.delta = next_ent.delta + pull_add;
               wave_in.rest = '0;
            end
            default: begin
            end
         endcase
      end else if (!(wave_ff.valid && hold)) begin
         wave_in.valid = 1'b0;
      end
      if (!up_wave.valid && wave_ff.valid && hold) begin
         wave_in = wave_ff;
      end
   end

   // Advance wave token
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= '0;
      end else begin
         wave_ff <= wave_in;
      end
   end

   // Hold entry payload
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign down_wave = wave_ff;
   assign ent_out   = ent_ff;

endmodule

`default_nettype wire

FILE: rtl/delta_list_timeout_queue.sv
// Top level of the delta list timeout queue: request intake, cell chain, result register.
`default_nettype none

// A bounded ordered queue of timeouts kept as a delta list in a chain of
// QUEUE_DEPTH cells, slot 0 being the head. An insert (req_tuser = 0) places
// the entry after all entries with the same or earlier expiry time and trims
// its successor's delta; a full queue drops it with status 2. A remove
// (req_tuser = 1) takes out the first entry with matching handler and
// argument and adds its delta to the successor; status 3 if none matches.
// Each request yields one result carrying the status, the head entry and the
// entry count. A request travels as a token down the chain, one cell per
// cycle, and its result is registered when the token leaves the last cell;
// the next request can be taken from the same cycle as that result is shown,
// so only one request is in the chain at a time. The next request is taken
// once the token has left the chain, even while the previous result waits;
// a result that is still waiting when the following token arrives holds
// that token in the last cell and the input stays stalled until the result
// is taken. No clearing pass is needed after reset.
module delta_list_timeout_queue
   import dltq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output wire logic        req_tready,
   // delay_ms [31:0], handler_id [39:32], arg_tag [55:40]
   input  wire logic [55:0] req_tdata,
   // req_type [0]
   input  wire logic [0:0]  req_tuser,
   output wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // status [1:0], head_valid [2], head_delay [34:3], head_handler [42:35],
   // head_arg [58:43], entry_count [63:59]
   output wire logic [63:0] rsp_tdata
);

   logic             busy_ff;
   logic             busy_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [63:0]      rsp_data_ff;
   logic [63:0]      rsp_data_in;

   wave_type  wave_chain [QUEUE_DEPTH+1];
   entry_type ent_chain  [QUEUE_DEPTH+1];
   logic      occ        [QUEUE_DEPTH];

   logic      accept;
   logic      done;
   logic      stall;
   logic      capture;
   wave_type  launch;
   wave_type  last;
   logic [STATUS_W-1:0] status;
   entry_type head;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;

   // Build the token for a new request
   always_comb begin
      launch             = '0;
      launch.valid       = accept;
      launch.mode        = MODE_SEARCH;
      launch.rest        = req_tdata[31:0];
      launch.ent.delta   = req_tdata[31:0];
      launch.ent.handler = req_tdata[39:32];
      launch.ent.arg     = req_tdata[55:40];
      if (req_tuser[0] == REQ_REMOVE) begin
         launch.op = OP_REM;
      end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
         launch.op = OP_NOP;
      end else begin
         launch.op = OP_INS;
      end
   end

   assign wave_chain[0]           = launch;
   assign ent_chain[QUEUE_DEPTH]  = '0;

   // Chain of cells
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign occ[i] = (count_ff > CNT_W'(i));
      dltq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .up_wave   (wave_chain[i]),
         .occupied  (occ[i]),
         .hold      ((i == QUEUE_DEPTH - 1) && stall),
         .next_ent  (ent_chain[i+1]),
         .down_wave (wave_chain[i+1]),
         .ent_out   (ent_chain[i])
      );
   end

   assign last    = wave_chain[QUEUE_DEPTH];
   assign head    = ent_chain[0];
   assign done    = last.valid;
   assign stall   = rsp_valid_ff && !rsp_tready;
   assign capture = done && !stall;

   // Decide status and new count when the token leaves the chain
   always_comb begin
      count_in = count_ff;
      if (last.op == OP_NOP) begin
         status = ST_FULL;
      end else if (last.op == OP_INS) begin
         status   = ST_INSERTED;
         count_in = count_ff + CNT_W'(1);
      end else if (last.hit) begin
         status   = ST_REMOVED;
         count_in = count_ff - CNT_W'(1);
      end else begin
         status = ST_NOT_FOUND;
      end
      if (!capture) begin
         count_in = count_ff;
      end
   end

   // Format result item
   always_comb begin
      rsp_data_in        = rsp_data_ff;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      if (capture) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in        = '0;
         rsp_data_in[1:0]   = status;
         rsp_data_in[63:59] = COUNT_W'(count_in);
         if (count_in != '0) begin
            rsp_data_in[2]     = 1'b1;
            rsp_data_in[34:3]  = head.delta;
            rsp_data_in[42:35] = head.handler;
            rsp_data_in[58:43] = head.arg;
         end
      end
   end

   assign busy_in = accept ? 1'b1 : (capture ? 1'b0 : busy_ff);

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/dltq_checker.sv
// Port-level checks of the delta list timeout queue, bound to the top level.
`default_nettype none

module dltq_checker
   import dltq_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic [63:0] rsp_tdata
);

   // One request in the chain at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while chain busy");

   // A successful insert leaves a head entry
   a_insert_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_INSERTED)) |-> rsp_tdata[2])
      else $error("insert without head entry");

   // A drop only happens on a full queue
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] == ST_FULL)) |->
         (rsp_tdata[63:59] == COUNT_W'(QUEUE_DEPTH)))
      else $error("drop reported with free slots");

   // Nonzero count implies a head entry
   a_count_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[63:59] != '0)) |-> rsp_tdata[2])
      else $error("entries held but no head shown");

   // Empty queue shows a zero head
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[2]) |-> (rsp_tdata[58:3] == '0))
      else $error("empty queue shows head data");

endmodule

bind delta_list_timeout_queue dltq_checker u_dltq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
